[design/bms_pkg.sv]
// bounded multiset table: shared types, operation codes and default sizes
// no dependencies
package bms_pkg;

   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_ITEM_WIDTH = 32;
   localparam int VALUE_W        = 32;
   localparam int OCC_W          = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [VALUE_W-1:0] item_value;
   } req_word_type;

   typedef struct packed {
      logic             op_ok;
      logic             present;
      logic [OCC_W-1:0] occurrences;
      logic [OCC_W-1:0] fill_count;
      logic             is_empty;
   } rsp_word_type;

   typedef struct packed {
      logic shift_en;
      logic wr_en;
   } cell_ctl_type;

endpackage

[design/bms_cell.sv]
// bounded multiset table: one storage cell of the entry chain
// depends on bms_pkg for the cell control struct
module bms_cell
   import bms_pkg::*;
#(
   parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic                  wr_sel,
   input  logic [ITEM_WIDTH-1:0] wr_data,
   input  logic [ITEM_WIDTH-1:0] next_entry,
   output logic [ITEM_WIDTH-1:0] entry
);

   logic [ITEM_WIDTH-1:0] entry_ff;
   logic [ITEM_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.wr_en && wr_sel) begin
         entry_in = wr_data;
      end else if (ctl.shift_en) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[design/bms_ctrl.sv]
// bounded multiset table: sequencer that rotates the chain past the head compare
// depends on bms_pkg for words, op codes and state type
module bms_ctrl
   import bms_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int ITEM_WIDTH = DEF_ITEM_WIDTH,
   parameter int CNT_W      = $clog2(CAPACITY + 1),
   parameter int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic [ITEM_WIDTH-1:0] head_entry,
   output cell_ctl_type          cell_ctl,
   output logic [IDX_W-1:0]      wr_idx,
   output logic [ITEM_WIDTH-1:0] wr_data
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [ITEM_WIDTH-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      len_ff, len_in;
   logic [CNT_W-1:0]      left_ff, left_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic                  drop_ff, drop_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_ff, rsp_in;

   logic                  head_match;
   logic                  room;
   logic [CNT_W-1:0]      occ_fin;
   logic [CNT_W-1:0]      len_fin;

   assign head_match = (head_entry == val_ff);
   assign room       = (len_ff < CAP_CNT);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      occ_in       = occ_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cell_ctl     = '0;
      wr_idx       = '0;
      wr_data      = head_entry;
      occ_fin      = occ_ff;
      len_fin      = len_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in   = req_word.op;
               val_in  = ITEM_WIDTH'(req_word.item_value);
               left_in = len_ff;
               occ_in  = '0;
               drop_in = 1'b0;
               if (req_word.op == OP_CLEAR) begin
                  len_in   = '0;
                  state_in = ST_FINISH;
               end else if (len_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // head leaves cell zero and either drops out or rejoins at the tail
            cell_ctl.shift_en = 1'b1;
            left_in           = left_ff - 1'b1;
            if (op_ff == OP_REMOVE && head_match && !drop_ff) begin
               drop_in = 1'b1;
               len_in  = len_ff - 1'b1;
            end else begin
               cell_ctl.wr_en = 1'b1;
               wr_idx         = IDX_W'(len_ff - 1'b1);
               occ_in         = occ_ff + CNT_W'(head_match);
            end
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            wr_idx  = IDX_W'(len_ff);
            wr_data = val_ff;
            if (op_ff == OP_ADD && room) begin
               occ_fin = occ_ff + 1'b1;
               len_fin = len_ff + 1'b1;
            end
            if (!rsp_valid_ff || rsp_ready) begin
               cell_ctl.wr_en = (op_ff == OP_ADD) && room;
               len_in         = len_fin;
               rsp_valid_in   = 1'b1;
               case (op_ff)
                  OP_ADD:    rsp_in.op_ok = room;
                  OP_REMOVE: rsp_in.op_ok = drop_ff;
                  default:   rsp_in.op_ok = 1'b1;
               endcase
               rsp_in.present     = (occ_fin != '0);
               rsp_in.occurrences = OCC_W'(occ_fin);
               rsp_in.fill_count  = OCC_W'(len_fin);
               rsp_in.is_empty    = (len_fin == '0);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      left_ff <= left_in;
      occ_ff  <= occ_in;
      drop_ff <= drop_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

[design/bounded_multiset_table_top.sv]
// A bag of up to CAPACITY values of ITEM_WIDTH bits held in a chain of cells.
// Add, remove, query and clear each return one word with the outcome and the
// bag as it stands afterwards. For add, remove and query the held entries
// rotate one cell a cycle past the compare at cell zero, so every entry is seen
// once; clear and any op on an empty bag skip the scan. The result register lets
// a new word in while a result waits to be taken. The order of entries inside
// the chain is not kept.
// depends on bms_pkg, bms_ctrl and bms_cell
module bounded_multiset_table_top
   import bms_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int ITEM_WIDTH = DEF_ITEM_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   cell_ctl_type          cell_ctl;
   logic [IDX_W-1:0]      wr_idx;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic [ITEM_WIDTH-1:0] entry [CAPACITY];

   bms_ctrl #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .head_entry (entry[0]),
      .cell_ctl   (cell_ctl),
      .wr_idx     (wr_idx),
      .wr_data    (wr_data)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [ITEM_WIDTH-1:0] next_entry;
      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = entry[i];
      end else begin : g_body
         assign next_entry = entry[i+1];
      end
      bms_cell #(
         .ITEM_WIDTH (ITEM_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .wr_sel     (wr_idx == IDX_W'(i)),
         .wr_data    (wr_data),
         .next_entry (next_entry),
         .entry      (entry[i])
      );
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("word accepted while previous one still in work");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      cell_ctl.wr_en |-> (CNT_W'(wr_idx) < CNT_W'(CAPACITY)))
      else $error("cell write beyond capacity");

   a_result_follows_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised without work in progress");
`endif

endmodule
